/* rtl/kls_pkg.sv */
package kls_pkg;

  // Kind of the token that is currently open
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_CONST = 2'd2,
    KIND_OP    = 2'd3
  } kind_t;

  // Token class codes carried in each record
  localparam logic [2:0] CLS_KEYWORD  = 3'd0;
  localparam logic [2:0] CLS_IDENT    = 3'd1;
  localparam logic [2:0] CLS_CONSTANT = 3'd2;
  localparam logic [2:0] CLS_OPERATOR = 3'd3;
  localparam logic [2:0] CLS_SYMBOL   = 3'd4;

  // Keyword table: if, for, do, while, int, float (padded with zeros)
  localparam int NUM_KW = 6;
  localparam int KW_SLOTS = 8;
  localparam int KW_LEN [NUM_KW] = '{2, 3, 2, 5, 3, 5};
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i",   "l",   "e",   8'h00, 8'h00, 8'h00},
    '{"i", "n", "t",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o",   "a",   "t",   8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } char_word_t;

  typedef struct packed {
    logic [2:0]  token_class;
    logic [2:0]  keyword_index;
    logic [15:0] start_pos;
    logic [5:0]  token_length;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        too_long;
    logic        last_of_run;
  } token_word_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == ">" || c == "<" || c == "=" || c == "!";
  endfunction

endpackage

/* rtl/keyword_lexer_stream.sv */
// Streaming keyword lexer, one ASCII character per input word.
// Input channel char_valid/char_ready/char_word carries the character and an
// end_of_text flag; output channel token_valid/token_ready/token_word carries
// one token record per word (class, keyword index, start position, length,
// first two characters, too_long, last_of_run).
// Each accepted character is classified and folded into the open token in
// the same cycle; the records it closes (none, one or two) are written into
// a four-entry record queue. A record is offered on token_word in the cycle
// after the character that closes it is accepted, when the queue is empty.
// Throughput: one character per cycle while the receiver takes one record
// per cycle and char_ready stays high; the queue absorbs the extra record
// of a character that closes two. char_ready is high while the queue holds
// at most two records, so a stalled receiver backs up the input once three
// or four records wait.
// Reset empties the queue, drops any open token and restarts the position
// counter at zero; the counter also restarts after a character flagged
// end_of_text, and any token still open at that point is emitted.
module keyword_lexer_stream
  import kls_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 63,
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  char_word_t  char_word,
  output logic        token_valid,
  input  logic        token_ready,
  output token_word_t token_word
);

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS = $clog2(FIFO_DEPTH + 1);

  // Open token state
  kind_t                pending_kind, pending_kind_next;
  logic [LEN_BITS-1:0]  open_length, open_length_next;
  logic [NUM_KW-1:0]    keyword_hits, keyword_hits_next;
  logic [POS_BITS-1:0]  open_start, open_start_next;
  logic [POS_BITS-1:0]  char_position, char_position_next;
  logic [7:0]           held_first, held_first_next;
  logic [7:0]           held_second, held_second_next;
  logic                 overflow_seen, overflow_seen_next;

  // Record queue
  token_word_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [FILL_BITS-1:0] fill;

  logic                 accept, pop;
  logic [7:0]           c;
  logic                 eot;
  logic                 extend;
  kind_t                open_kind;
  logic [NUM_KW-1:0]    open_hits, ext_hits;
  logic [LEN_BITS-1:0]  ext_len;
  logic                 ext_ovf;
  logic [7:0]           ext_second;
  token_word_t          rec_cur, rec_ext, rec_open;
  token_word_t          rec0, rec1;
  logic [1:0]           push_n;

  // Build one record from a token's state
  function automatic token_word_t build_record(
    input kind_t               kind,
    input logic [NUM_KW-1:0]   hits,
    input logic [LEN_BITS-1:0] len,
    input logic                ovf,
    input logic [POS_BITS-1:0] start,
    input logic [7:0]          first,
    input logic [7:0]          second
  );
    token_word_t             r;
    logic [LEN_BITS+5:0]     len_ext;
    logic [POS_BITS+15:0]    pos_ext;
    logic                    found;
    r = '0;
    found = 1'b0;
    len_ext = {6'b0, len};
    pos_ext = {16'b0, start};
    for (int k = 0; k < NUM_KW; k++) begin
      if (!found && hits[k] && len == LEN_BITS'(KW_LEN[k]) && !ovf) begin
        found = 1'b1;
        r.keyword_index = 3'(k);
      end
    end
    unique case (kind)
      KIND_WORD:  r.token_class = found ? CLS_KEYWORD : CLS_IDENT;
      KIND_CONST: r.token_class = CLS_CONSTANT;
      KIND_OP:    r.token_class = CLS_OPERATOR;
      KIND_NONE:  r.token_class = CLS_SYMBOL;
      default:    r.token_class = CLS_SYMBOL;
    endcase
    if (kind != KIND_WORD || !found) begin
      r.keyword_index = 3'd0;
    end
    r.start_pos    = pos_ext[15:0];
    r.token_length = len_ext[5:0];
    r.first_char   = first;
    r.second_char  = (len >= LEN_BITS'(2)) ? second : 8'h00;
    r.too_long     = (kind == KIND_WORD || kind == KIND_CONST) ? ovf : 1'b0;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign accept      = char_valid && char_ready;
  assign pop         = token_valid && token_ready;
  assign char_ready  = fill <= FILL_BITS'(FIFO_DEPTH - 2);
  assign token_valid = fill != '0;
  assign token_word  = fifo_mem[rd_ptr];

  assign c   = char_word.char_in;
  assign eot = char_word.end_of_text;

  // Classify the character against the open token
  assign extend = (pending_kind == KIND_WORD  && (is_letter(c) || is_digit(c))) ||
                  (pending_kind == KIND_CONST && is_digit(c)) ||
                  (pending_kind == KIND_OP    && is_op(c));

  always_comb begin
    if (is_letter(c)) begin
      open_kind = KIND_WORD;
    end else if (is_digit(c)) begin
      open_kind = KIND_CONST;
    end else if (is_op(c)) begin
      open_kind = KIND_OP;
    end else begin
      open_kind = KIND_NONE;
    end
  end

  // Per-keyword still-matching flags
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      open_hits[k] = KW_TEXT[k][0] == c;
      ext_hits[k]  = keyword_hits[k] &&
                     open_length < LEN_BITS'(KW_LEN[k]) &&
                     KW_TEXT[k][open_length[2:0]] == c;
    end
  end

  // Extended token: saturate length, latch second character
  assign ext_len    = (open_length >= LEN_MAX) ? open_length : open_length + 1'b1;
  assign ext_ovf    = overflow_seen || (open_length >= LEN_MAX);
  assign ext_second = (open_length == LEN_BITS'(1)) ? c : held_second;

  assign rec_cur  = build_record(pending_kind, keyword_hits, open_length, overflow_seen,
                                 open_start, held_first, held_second);
  assign rec_ext  = build_record(pending_kind, ext_hits, ext_len, ext_ovf,
                                 open_start, held_first, ext_second);
  assign rec_open = build_record(open_kind, open_hits, LEN_BITS'(1), 1'b0,
                                 char_position, c, 8'h00);

  // Next token state and the records closed by this character
  always_comb begin
    pending_kind_next  = pending_kind;
    open_length_next   = open_length;
    keyword_hits_next  = keyword_hits;
    open_start_next    = open_start;
    held_first_next    = held_first;
    held_second_next   = held_second;
    overflow_seen_next = overflow_seen;
    rec0   = '0;
    rec1   = '0;
    push_n = 2'd0;
    char_position_next = eot ? '0 : char_position + 1'b1;

    if (extend) begin
      open_length_next   = ext_len;
      keyword_hits_next  = ext_hits;
      held_second_next   = ext_second;
      overflow_seen_next = ext_ovf;
      if (pending_kind == KIND_OP || eot) begin
        rec0 = rec_ext;
        push_n = 2'd1;
        pending_kind_next = KIND_NONE;
      end
    end else begin
      pending_kind_next  = eot ? KIND_NONE : open_kind;
      open_length_next   = LEN_BITS'(1);
      keyword_hits_next  = open_hits;
      open_start_next    = char_position;
      held_first_next    = c;
      held_second_next   = 8'h00;
      overflow_seen_next = 1'b0;
      if (pending_kind != KIND_NONE) begin
        rec0 = rec_cur;
        if (open_kind == KIND_NONE || eot) begin
          rec1 = rec_open;
          push_n = 2'd2;
        end else begin
          push_n = 2'd1;
        end
      end else if (open_kind == KIND_NONE || eot) begin
        rec0 = rec_open;
        push_n = 2'd1;
      end
    end

    // Mark the last record of this character
    if (push_n == 2'd2) begin
      rec1.last_of_run = 1'b1;
    end else begin
      rec0.last_of_run = 1'b1;
    end
  end

  // Advance token state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind  <= KIND_NONE;
      open_length   <= '0;
      keyword_hits  <= '0;
      open_start    <= '0;
      char_position <= '0;
      held_first    <= '0;
      held_second   <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      pending_kind  <= pending_kind_next;
      open_length   <= open_length_next;
      keyword_hits  <= keyword_hits_next;
      open_start    <= open_start_next;
      char_position <= char_position_next;
      held_first    <= held_first_next;
      held_second   <= held_second_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Write closed records into the queue
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= rec0;
      if (push_n == 2'd2) begin
        fifo_mem[wr_ptr + 1'b1] <= rec1;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (accept ? FILL_BITS'(push_n) : '0) - FILL_BITS'(pop);
    end
  end

  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(FIFO_DEPTH))
    else $error("record queue overfilled");

  // Fill count tracks pushes when nothing is popped
  assert property (@(posedge clk) disable iff (rst)
    accept && !pop |=> fill == $past(fill) + FILL_BITS'($past(push_n)))
    else $error("fill count does not follow pushes");

  // End of text closes everything and restarts position
  assert property (@(posedge clk) disable iff (rst)
    accept && eot |=> pending_kind == KIND_NONE && char_position == '0)
    else $error("end of text left a token open");

  // An open token always has a length
  assert property (@(posedge clk) disable iff (rst)
    pending_kind != KIND_NONE |-> open_length != '0)
    else $error("open token with zero length");

  // Overflow only at saturated length
  assert property (@(posedge clk) disable iff (rst)
    pending_kind != KIND_NONE && overflow_seen |-> open_length == LEN_MAX)
    else $error("overflow without saturated length");

endmodule

/* tb/tb_keyword_lexer_stream.sv */
module tb_keyword_lexer_stream;
  timeunit 1ns;
  timeprecision 1ps;
  import kls_pkg::*;

  localparam int MAX_LEN = 63;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CHARS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_ready;
  char_word_t char_word = '0;
  logic token_valid;
  logic token_ready = 1'b0;
  token_word_t token_word;

  always #5 clk = ~clk;

  keyword_lexer_stream u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_word   (char_word),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_word  (token_word)
  );

  // Lexer state mirrored by the predictor
  kind_t       open_kind;
  logic [5:0]  open_len;
  logic [5:0]  kw_live;
  logic [15:0] open_pos;
  logic [15:0] next_pos;
  logic [7:0]  open_c0;
  logic [7:0]  open_c1;
  logic        open_over;

  string kw_spelling [6] = '{"if", "for", "do", "while", "int", "float"};
  string op_set = "+-*/%<>=!";
  string sep_set = " ;(){},.\t\n ";

  token_word_t closed_now [$];
  token_word_t predicted_tokens [$];
  char_word_t  char_backlog [$];
  logic [7:0]  text_buf [$];

  int idle_pct = 20;
  int chars_queued = 0;
  int chars_taken = 0;
  int records_checked = 0;
  int mismatches = 0;
  int overlong_seen = 0;
  int class_tally [5] = '{0, 0, 0, 0, 0};
  int cycle_count = 0;

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit numeral_c(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit op_c(logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < op_set.len(); i++) begin
      if (op_set[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void reset_lexer();
    open_kind = KIND_NONE;
    open_len = '0;
    kw_live = '0;
    open_pos = '0;
    next_pos = '0;
    open_c0 = '0;
    open_c1 = '0;
    open_over = 1'b0;
  endfunction

  // Close the open token, if any, into a record
  function automatic void close_token();
    token_word_t r;
    if (open_kind == KIND_NONE) return;
    r = '0;
    case (open_kind)
      KIND_WORD: begin
        r.token_class = CLS_IDENT;
        for (int k = 0; k < 6; k++) begin
          if (r.token_class != CLS_KEYWORD && kw_live[k] && !open_over &&
              open_len == kw_spelling[k].len()) begin
            r.token_class = CLS_KEYWORD;
            r.keyword_index = k[2:0];
          end
        end
      end
      KIND_CONST: r.token_class = CLS_CONSTANT;
      default: r.token_class = CLS_OPERATOR;
    endcase
    r.start_pos = open_pos;
    r.token_length = open_len;
    r.first_char = open_c0;
    r.second_char = (open_len >= 2) ? open_c1 : 8'h00;
    r.too_long = (open_kind == KIND_OP) ? 1'b0 : open_over;
    closed_now.push_back(r);
    open_kind = KIND_NONE;
  endfunction

  function automatic void open_token(kind_t kind, logic [7:0] c);
    open_kind = kind;
    open_len = 6'd1;
    open_pos = next_pos;
    open_c0 = c;
    open_c1 = 8'h00;
    open_over = 1'b0;
    kw_live = '0;
    if (kind == KIND_WORD) begin
      for (int k = 0; k < 6; k++) begin
        if (kw_spelling[k][0] == c) kw_live[k] = 1'b1;
      end
    end
  endfunction

  // Extend the open token; drop keywords that no longer match
  function automatic void grow_token(logic [7:0] c);
    int at;
    at = open_len;
    for (int k = 0; k < 6; k++) begin
      if (!(at < kw_spelling[k].len() && kw_spelling[k][at] == c)) kw_live[k] = 1'b0;
    end
    if (at == 1) open_c1 = c;
    if (open_len >= MAX_LEN) open_over = 1'b1;
    else open_len = open_len + 6'd1;
  endfunction

  // Advance the predictor by one character word, queue the records it closes
  function automatic void lex_char(char_word_t w);
    logic [7:0] c;
    token_word_t r;
    c = w.char_in;
    closed_now.delete();
    if (open_kind == KIND_WORD && (alpha_c(c) || numeral_c(c))) begin
      grow_token(c);
    end else if (open_kind == KIND_CONST && numeral_c(c)) begin
      grow_token(c);
    end else if (open_kind == KIND_OP && op_c(c)) begin
      grow_token(c);
      close_token();
    end else begin
      close_token();
      if (alpha_c(c)) open_token(KIND_WORD, c);
      else if (numeral_c(c)) open_token(KIND_CONST, c);
      else if (op_c(c)) open_token(KIND_OP, c);
      else begin
        r = '0;
        r.token_class = CLS_SYMBOL;
        r.start_pos = next_pos;
        r.token_length = 6'd1;
        r.first_char = c;
        closed_now.push_back(r);
      end
    end
    if (w.end_of_text) begin
      close_token();
      next_pos = '0;
    end else begin
      next_pos = next_pos + 16'd1;
    end
    if (closed_now.size() > 0) begin
      r = closed_now.pop_back();
      r.last_of_run = 1'b1;
      closed_now.push_back(r);
    end
    foreach (closed_now[i]) predicted_tokens.push_back(closed_now[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, int got, int want, int pos);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d (token at %0d)", name, got, want, pos));
    end
  endtask

  task automatic check_token(token_word_t got);
    token_word_t want;
    if (predicted_tokens.size() == 0) begin
      report_mismatch($sformatf("record with nothing predicted: class %0d pos %0d",
                                got.token_class, got.start_pos));
      return;
    end
    want = predicted_tokens.pop_front();
    records_checked++;
    compare_field("token_class", got.token_class, want.token_class, want.start_pos);
    compare_field("keyword_index", got.keyword_index, want.keyword_index, want.start_pos);
    compare_field("start_pos", got.start_pos, want.start_pos, want.start_pos);
    compare_field("token_length", got.token_length, want.token_length, want.start_pos);
    compare_field("first_char", got.first_char, want.first_char, want.start_pos);
    compare_field("second_char", got.second_char, want.second_char, want.start_pos);
    compare_field("too_long", got.too_long, want.too_long, want.start_pos);
    compare_field("last_of_run", got.last_of_run, want.last_of_run, want.start_pos);
    if (want.token_class <= CLS_SYMBOL) class_tally[want.token_class]++;
    if (want.too_long) overlong_seen++;
  endtask

  // Drive character words from the backlog, holding each until taken
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        lex_char(char_word);
        chars_taken++;
      end
      if (!char_valid || char_ready) begin
        if (char_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          char_valid <= 1'b1;
          char_word <= char_backlog.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Take token words and check them, stalling at random
  always @(posedge clk) begin
    if (rst) begin
      token_ready <= 1'b0;
    end else begin
      if (token_valid && token_ready) check_token(token_word);
      token_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records outstanding", cycle_count,
               predicted_tokens.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_char(logic [7:0] c, bit eot);
    char_word_t w;
    w.char_in = c;
    w.end_of_text = eot;
    char_backlog.push_back(w);
    chars_queued++;
  endtask

  task automatic queue_text(string s, bit eot);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], eot && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    while (char_backlog.size() != 0 || char_valid || predicted_tokens.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(3) == 0) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(2) == 0) return 8'h30 + 8'($urandom_range(9));
    return rand_letter();
  endfunction

  // Append one well-formed token, or noise, to the text buffer
  task automatic add_token();
    int pick;
    int n;
    string kw;
    pick = $urandom_range(99);
    if (pick < 25) begin
      kw = kw_spelling[$urandom_range(5)];
      for (int i = 0; i < kw.len(); i++) text_buf.push_back(kw[i]);
      case ($urandom_range(9))
        0: void'(text_buf.pop_back());
        1: text_buf.push_back(rand_alnum());
        2: begin
          void'(text_buf.pop_back());
          text_buf.push_back(rand_letter());
        end
        default: ;
      endcase
    end else if (pick < 45) begin
      n = ($urandom_range(24) == 0) ? $urandom_range(58, 75) : $urandom_range(1, 8);
      text_buf.push_back(rand_letter());
      for (int i = 1; i < n; i++) text_buf.push_back(rand_alnum());
    end else if (pick < 58) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) text_buf.push_back(8'h30 + 8'($urandom_range(9)));
    end else if (pick < 72) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) text_buf.push_back(op_set[$urandom_range(op_set.len() - 1)]);
    end else if (pick < 88) begin
      text_buf.push_back(sep_set[$urandom_range(sep_set.len() - 1)]);
    end else begin
      text_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  // Build one text of a few tokens; most texts end with the end flag
  task automatic build_text();
    bit eot;
    text_buf.delete();
    repeat ($urandom_range(1, 12)) add_token();
    eot = ($urandom_range(4) != 0);
    foreach (text_buf[i]) queue_char(text_buf[i], eot && i == text_buf.size() - 1);
  endtask

  initial begin
    int start_at;
    int n;
    bit paused;
    paused = 1'b0;
    reset_lexer();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: every keyword, all operators, pairs and a triple, NUL and 0xFF
    queue_text("if+for-do*while/int%float", 1'b1);
    queue_char(8'h00, 1'b0);
    queue_text("a9 12b<=>!!!", 1'b0);
    queue_char(8'hFF, 1'b1);
    wait_drained();

    // Random texts, with a stretch of no random idling and one full drain midway
    start_at = chars_queued;
    while (chars_queued - start_at < RANDOM_CHARS) begin
      n = chars_queued - start_at;
      idle_pct = (n >= 250 && n < 400) ? 0 : 20;
      if (!paused && n >= 500) begin
        wait_drained();
        repeat (5) @(negedge clk);
        paused = 1'b1;
      end
      build_text();
      while (char_backlog.size() > 16) @(negedge clk);
    end
    idle_pct = 20;
    wait_drained();
    repeat (20) @(negedge clk);

    $display("Lexed %0d characters into %0d records: %0d keyword, %0d identifier, %0d constant,",
             chars_taken, records_checked, class_tally[0], class_tally[1], class_tally[2]);
    $display("%0d operator, %0d symbol, %0d overlong; %0d mismatches",
             class_tally[3], class_tally[4], overlong_seen, mismatches);
    if (mismatches == 0 && predicted_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
